// ===== rtl/albvp_pkg.sv =====
// ----------------------------------------------------------------------------
// ASCII line byte-value parser package
// Shared constants, types and character helpers for the line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package albvp_pkg;

  // Line buffer capacity; a line holds at most LINE_CAP-1 characters.
  localparam int unsigned LINE_CAP = 16;
  localparam int unsigned LEN_W    = $clog2(LINE_CAP);

  // Magnitude saturates at this value.
  localparam int unsigned MAG_W     = 9;
  localparam int unsigned SAT_LIMIT = 256;
  // Wide enough for the largest magnitude times sixteen plus a digit.
  localparam int unsigned ACC_W     = 13;

  // Character codes.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // Parser phase within one line.
  typedef enum logic [2:0] {
    PH_WS,
    PH_SIGN,
    PH_ZERO,
    PH_ZEROX,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  // Number base.
  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_OCT,
    BASE_HEX
  } base_t;

  // Decoded hex digit: valid flag and value.
  typedef struct packed {
    logic       vld;
    logic [3:0] val;
  } digit_t;

  // Classify a character as a hex digit (0-9, a-f, A-F).
  function automatic digit_t hex_digit(input logic [7:0] c);
    digit_t d;
    d.vld = 1'b0;
    d.val = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d.vld = 1'b1;
      d.val = 4'(c - CH_ZERO);
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      d.vld = 1'b1;
      d.val = 4'(c - CH_LO_A + 8'd10);
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      d.vld = 1'b1;
      d.val = 4'(c - CH_UP_A + 8'd10);
    end
    return d;
  endfunction

  // Digit of the given base, or invalid when out of range for it.
  function automatic digit_t base_digit(input logic [7:0] c, input base_t b);
    digit_t d;
    d = hex_digit(c);
    if (b == BASE_OCT && d.val > 4'd7) d.vld = 1'b0;
    if (b == BASE_DEC && d.val > 4'd9) d.vld = 1'b0;
    return d;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ascii_line_byte_value_parser.sv =====
// ----------------------------------------------------------------------------
// ASCII line byte-value parser
// Gathers received bytes into lines and reports each non-empty line as a byte
// value, an invalid line or a dropped over-long line.
// ----------------------------------------------------------------------------
// Path: a line-ending beat is taken into the input register, and its result
// beat is then written to the result register.
// Throughput: one input beat per cycle; the input register stalls only when
// it holds a result-producing beat and the result register is still full.
// Reset: rst_n low clears both pipeline valids and the line parse state.
`default_nettype none

module ascii_line_byte_value_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // [1:0] status, [9:2] value, [15:10] zero
);

  // Input register
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;

  // Line parse state
  logic [albvp_pkg::LEN_W-1:0] len_r, len_nxt;
  albvp_pkg::phase_t           phase_r, phase_nxt;
  albvp_pkg::base_t            base_r, base_nxt;
  logic                        neg_r, neg_nxt;
  logic [albvp_pkg::MAG_W-1:0] mag_r, mag_nxt;
  logic                        inv_r, inv_nxt;

  // Result register
  logic       out_vld_r;
  logic [1:0] out_status_r, res_status;
  logic [7:0] out_value_r, res_value;

  logic res_vld;
  logic out_free;
  logic s1_adv;

  // Handshake and advance control
  assign out_free  = !out_vld_r || out_tready;
  assign s1_adv    = s1_vld_r && (!res_vld || out_free);
  assign in_tready = !s1_vld_r || s1_adv;

  // Character feed: next parse state for the held byte
  logic                        is_eol;
  logic                        has_room;
  albvp_pkg::digit_t           dig_oct;
  albvp_pkg::digit_t           dig_hex;
  albvp_pkg::digit_t           dig_cur;
  logic [albvp_pkg::ACC_W-1:0] acc;

  always_comb begin
    is_eol   = (s1_byte_r == albvp_pkg::CH_CR) || (s1_byte_r == albvp_pkg::CH_LF);
    has_room = (albvp_pkg::ACC_W'(len_r) < albvp_pkg::ACC_W'(albvp_pkg::LINE_CAP - 1));
    dig_oct  = albvp_pkg::base_digit(s1_byte_r, albvp_pkg::BASE_OCT);
    dig_hex  = albvp_pkg::base_digit(s1_byte_r, albvp_pkg::BASE_HEX);
    dig_cur  = albvp_pkg::base_digit(s1_byte_r, base_r);
    case (base_r)
      albvp_pkg::BASE_HEX: acc = (albvp_pkg::ACC_W'(mag_r) << 4) + albvp_pkg::ACC_W'(dig_cur.val);
      albvp_pkg::BASE_OCT: acc = (albvp_pkg::ACC_W'(mag_r) << 3) + albvp_pkg::ACC_W'(dig_cur.val);
      default:             acc = (albvp_pkg::ACC_W'(mag_r) << 3) + (albvp_pkg::ACC_W'(mag_r) << 1)
                                 + albvp_pkg::ACC_W'(dig_cur.val);
    endcase
  end

  // Next-state logic
  always_comb begin
    len_nxt   = len_r;
    phase_nxt = phase_r;
    base_nxt  = base_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    inv_nxt   = inv_r;
    if (is_eol || !has_room) begin
      // Line end or overflow: start a fresh line.  An empty line end is a no-op
      // that leaves the cleared state as it is.
      len_nxt   = '0;
      phase_nxt = albvp_pkg::PH_WS;
      base_nxt  = albvp_pkg::BASE_DEC;
      neg_nxt   = 1'b0;
      mag_nxt   = '0;
      inv_nxt   = 1'b0;
    end else begin
      len_nxt = len_r + 1'b1;
      if (!inv_r && phase_r != albvp_pkg::PH_DONE) begin
        case (phase_r)
          albvp_pkg::PH_WS, albvp_pkg::PH_SIGN: begin
            if (phase_r == albvp_pkg::PH_WS && albvp_pkg::is_space(s1_byte_r)) begin
              phase_nxt = phase_r;
            end else if (phase_r == albvp_pkg::PH_WS &&
                         (s1_byte_r == albvp_pkg::CH_PLUS ||
                          s1_byte_r == albvp_pkg::CH_MINUS)) begin
              neg_nxt   = (s1_byte_r == albvp_pkg::CH_MINUS);
              phase_nxt = albvp_pkg::PH_SIGN;
            end else if (s1_byte_r == albvp_pkg::CH_ZERO) begin
              phase_nxt = albvp_pkg::PH_ZERO;
            end else if (s1_byte_r >= albvp_pkg::CH_ONE &&
                         s1_byte_r <= albvp_pkg::CH_NINE) begin
              base_nxt  = albvp_pkg::BASE_DEC;
              mag_nxt   = albvp_pkg::MAG_W'(s1_byte_r - albvp_pkg::CH_ZERO);
              phase_nxt = albvp_pkg::PH_DIGITS;
            end else begin
              inv_nxt = 1'b1;
            end
          end
          albvp_pkg::PH_ZERO: begin
            if (s1_byte_r == albvp_pkg::CH_NUL) begin
              phase_nxt = albvp_pkg::PH_DONE;
            end else if (s1_byte_r == albvp_pkg::CH_LO_X ||
                         s1_byte_r == albvp_pkg::CH_UP_X) begin
              phase_nxt = albvp_pkg::PH_ZEROX;
            end else if (!dig_oct.vld) begin
              inv_nxt = 1'b1;
            end else begin
              base_nxt  = albvp_pkg::BASE_OCT;
              mag_nxt   = albvp_pkg::MAG_W'(dig_oct.val);
              phase_nxt = albvp_pkg::PH_DIGITS;
            end
          end
          albvp_pkg::PH_ZEROX: begin
            if (!dig_hex.vld) begin
              inv_nxt = 1'b1;
            end else begin
              base_nxt  = albvp_pkg::BASE_HEX;
              mag_nxt   = albvp_pkg::MAG_W'(dig_hex.val);
              phase_nxt = albvp_pkg::PH_DIGITS;
            end
          end
          albvp_pkg::PH_DIGITS: begin
            if (s1_byte_r == albvp_pkg::CH_NUL) begin
              phase_nxt = albvp_pkg::PH_DONE;
            end else if (!dig_cur.vld) begin
              inv_nxt = 1'b1;
            end else if (acc > albvp_pkg::ACC_W'(albvp_pkg::SAT_LIMIT)) begin
              mag_nxt = albvp_pkg::MAG_W'(albvp_pkg::SAT_LIMIT);
            end else begin
              mag_nxt = albvp_pkg::MAG_W'(acc);
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  // Result logic: a non-empty line end or an overflow character reports
  logic line_ok;

  always_comb begin
    line_ok = !inv_r &&
              (phase_r == albvp_pkg::PH_ZERO || phase_r == albvp_pkg::PH_DIGITS ||
               phase_r == albvp_pkg::PH_DONE) &&
              !(neg_r && mag_r != '0) &&
              (mag_r < albvp_pkg::MAG_W'(albvp_pkg::SAT_LIMIT));
    res_vld    = 1'b0;
    res_status = albvp_pkg::ST_OK;
    res_value  = 8'd0;
    if (is_eol) begin
      res_vld = (len_r != '0);
      if (line_ok) begin
        res_value = mag_r[7:0];
      end else begin
        res_status = albvp_pkg::ST_INVALID;
      end
    end else if (!has_room) begin
      res_vld    = 1'b1;
      res_status = albvp_pkg::ST_TOO_LONG;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      phase_r <= albvp_pkg::PH_WS;
      base_r  <= albvp_pkg::BASE_DEC;
      neg_r   <= 1'b0;
      mag_r   <= '0;
      inv_r   <= 1'b0;
    end else if (s1_adv) begin
      len_r   <= len_nxt;
      phase_r <= phase_nxt;
      base_r  <= base_nxt;
      neg_r   <= neg_nxt;
      mag_r   <= mag_nxt;
      inv_r   <= inv_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_adv && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_vld) begin
      out_status_r <= res_status;
      out_value_r  <= res_value;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_value_r, out_status_r};

  // Assertions
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(len_r) <= albvp_pkg::LINE_CAP - 1)
    else $error("line length beyond capacity");

  a_value_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_status_r == albvp_pkg::ST_OK || out_value_r == 8'd0))
    else $error("nonzero value on a failed line");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_status_r == albvp_pkg::ST_OK ||
                   out_status_r == albvp_pkg::ST_INVALID ||
                   out_status_r == albvp_pkg::ST_TOO_LONG))
    else $error("undefined status code");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_adv) |=> (s1_vld_r && $stable(s1_byte_r) && $stable(len_r)))
    else $error("held byte or line state changed while stalled");

  a_phase_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != albvp_pkg::PH_WS || inv_r || neg_r) |-> (len_r != '0))
    else $error("parse progress on an empty line");

endmodule

`default_nettype wire

// ===== verif/tb_ascii_line_byte_value_parser.sv =====
// ----------------------------------------------------------------------------
// Testbench for the ASCII line byte-value parser
// Streams directed and random text lines into the parser and checks every
// result beat against a line-by-line prediction of the number conversion.
// Both sides idle at random in three phases: sender light and receiver
// heavy, then the reverse, then no idling at all.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ascii_line_byte_value_parser;

  // Expected verdict for one finished line.
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] value;
  } line_verdict_t;

  // Tracks the line being received and holds the verdicts still owed.
  class line_verdict_board;
    int                error_count;
    int                result_count;
    line_verdict_t     owed[$];
    int                line_len;
    albvp_pkg::phase_t phase;
    albvp_pkg::base_t  base;
    bit                neg;
    int                mag;
    bit                bad;

    function new();
      error_count  = 0;
      result_count = 0;
      clear_line();
    endfunction

    function void clear_line();
      line_len = 0;
      phase    = albvp_pkg::PH_WS;
      base     = albvp_pkg::BASE_DEC;
      neg      = 1'b0;
      mag      = 0;
      bad      = 1'b0;
    endfunction

    // Value of a character as a digit of the base, or -1.
    function int digit_in_base(logic [7:0] c, albvp_pkg::base_t b);
      int d;
      d = -1;
      if (c >= albvp_pkg::CH_ZERO && c <= albvp_pkg::CH_NINE)
        d = int'(c - albvp_pkg::CH_ZERO);
      else if (c >= albvp_pkg::CH_LO_A && c <= albvp_pkg::CH_LO_F)
        d = int'(c - albvp_pkg::CH_LO_A) + 10;
      else if (c >= albvp_pkg::CH_UP_A && c <= albvp_pkg::CH_UP_F)
        d = int'(c - albvp_pkg::CH_UP_A) + 10;
      if (b == albvp_pkg::BASE_OCT && d > 7) d = -1;
      if (b == albvp_pkg::BASE_DEC && d > 9) d = -1;
      return d;
    endfunction

    // Advance the number scan by one character of the line.
    function void advance_scan(logic [7:0] c);
      int d;
      int radix;
      if (bad || phase == albvp_pkg::PH_DONE) return;
      case (phase)
        albvp_pkg::PH_WS, albvp_pkg::PH_SIGN: begin
          if (phase == albvp_pkg::PH_WS &&
              (c == albvp_pkg::CH_SP || c == albvp_pkg::CH_TAB ||
               c == albvp_pkg::CH_VT || c == albvp_pkg::CH_FF)) return;
          if (phase == albvp_pkg::PH_WS &&
              (c == albvp_pkg::CH_PLUS || c == albvp_pkg::CH_MINUS)) begin
            neg   = (c == albvp_pkg::CH_MINUS);
            phase = albvp_pkg::PH_SIGN;
          end else if (c == albvp_pkg::CH_ZERO) begin
            phase = albvp_pkg::PH_ZERO;
          end else if (c >= albvp_pkg::CH_ONE && c <= albvp_pkg::CH_NINE) begin
            base  = albvp_pkg::BASE_DEC;
            mag   = int'(c - albvp_pkg::CH_ZERO);
            phase = albvp_pkg::PH_DIGITS;
          end else begin
            bad = 1'b1;
          end
        end
        albvp_pkg::PH_ZERO: begin
          if (c == albvp_pkg::CH_NUL) begin
            phase = albvp_pkg::PH_DONE;
          end else if (c == albvp_pkg::CH_LO_X || c == albvp_pkg::CH_UP_X) begin
            phase = albvp_pkg::PH_ZEROX;
          end else begin
            d = digit_in_base(c, albvp_pkg::BASE_OCT);
            if (d < 0) begin
              bad = 1'b1;
            end else begin
              base  = albvp_pkg::BASE_OCT;
              mag   = d;
              phase = albvp_pkg::PH_DIGITS;
            end
          end
        end
        albvp_pkg::PH_ZEROX: begin
          d = digit_in_base(c, albvp_pkg::BASE_HEX);
          if (d < 0) begin
            bad = 1'b1;
          end else begin
            base  = albvp_pkg::BASE_HEX;
            mag   = d;
            phase = albvp_pkg::PH_DIGITS;
          end
        end
        default: begin
          if (c == albvp_pkg::CH_NUL) begin
            phase = albvp_pkg::PH_DONE;
          end else begin
            d = digit_in_base(c, base);
            if (d < 0) begin
              bad = 1'b1;
            end else begin
              radix = (base == albvp_pkg::BASE_HEX) ? 16 :
                      ((base == albvp_pkg::BASE_OCT) ? 8 : 10);
              mag   = mag * radix + d;
              if (mag > int'(albvp_pkg::SAT_LIMIT)) mag = int'(albvp_pkg::SAT_LIMIT);
            end
          end
        end
      endcase
    endfunction

    // Note one accepted input beat; a line end or an overflow owes a verdict.
    function void note_rx_byte(logic [7:0] c);
      line_verdict_t v;
      bit            ok;
      if (c == albvp_pkg::CH_CR || c == albvp_pkg::CH_LF) begin
        // An empty line produces nothing.
        if (line_len != 0) begin
          ok = !bad &&
               (phase inside {albvp_pkg::PH_ZERO, albvp_pkg::PH_DIGITS,
                              albvp_pkg::PH_DONE}) &&
               !(neg && mag != 0) && mag <= 255;
          v.status = ok ? albvp_pkg::ST_OK : albvp_pkg::ST_INVALID;
          v.value  = ok ? 8'(mag) : 8'd0;
          owed.push_back(v);
          clear_line();
        end
      end else if (line_len < int'(albvp_pkg::LINE_CAP) - 1) begin
        advance_scan(c);
        line_len++;
      end else begin
        // The character that would overflow the line is dropped with it.
        clear_line();
        v.status = albvp_pkg::ST_TOO_LONG;
        v.value  = 8'd0;
        owed.push_back(v);
      end
    endfunction

    task report(string msg);
      error_count++;
      if (error_count <= 100) $display("mismatch at %0t: %s", $time, msg);
    endtask

    // Compare one accepted result beat with the oldest verdict owed.
    task check_verdict(logic [15:0] beat);
      line_verdict_t v;
      result_count++;
      if (owed.size() == 0) begin
        report($sformatf("result %0d (%h) arrived with nothing owed", result_count, beat));
        return;
      end
      v = owed.pop_front();
      if (beat[1:0] !== v.status)
        report($sformatf("result %0d status %0d, predicted %0d",
                         result_count, beat[1:0], v.status));
      if (beat[9:2] !== v.value)
        report($sformatf("result %0d value %0d, predicted %0d",
                         result_count, beat[9:2], v.value));
      if (beat[15:10] !== 6'd0)
        report($sformatf("result %0d pad bits %b not zero", result_count, beat[15:10]));
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;           // [1:0] status, [9:2] value, [15:10] zero

  line_verdict_board sb = new();

  logic [7:0] rx_stream[$];
  logic [7:0] blank_set[4] = '{albvp_pkg::CH_SP, albvp_pkg::CH_TAB,
                               albvp_pkg::CH_VT, albvp_pkg::CH_FF};
  int         tx_idle_pct = 7;
  int         rx_idle_pct = 59;

  ascii_line_byte_value_parser u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Result side: check each accepted beat and stall at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sb.check_verdict(out_tdata);
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) rx_stream.push_back(s[i]);
  endfunction

  // Line end: CR, LF, or a CR LF pair (whose LF is an empty line).
  function automatic void add_eol();
    int pick;
    pick = $urandom_range(2);
    if (pick != 1) rx_stream.push_back(albvp_pkg::CH_CR);
    if (pick != 0) rx_stream.push_back(albvp_pkg::CH_LF);
  endfunction

  function automatic void add_line(string s);
    add_text(s);
    add_eol();
  endfunction

  // Send one beat, with random idle cycles ahead of it.
  task automatic send_beat(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_rx_byte(b);
  endtask

  initial begin
    int    kind;
    int    first;
    int    pos;
    int    v;
    int    n;
    int    waited;
    int    directed_len;
    string digits;
    string near_miss;
    logic [7:0] c;

    // Directed lines: limits, each base, signs, blanks and the odd cases.
    add_line("255");
    add_line("256");
    add_line("0");
    add_line("0xff");
    add_line("0XA");
    add_line("0377");
    add_line("-0");
    add_line("-1");
    add_line("+200");
    rx_stream.push_back(albvp_pkg::CH_SP);
    rx_stream.push_back(albvp_pkg::CH_TAB);
    rx_stream.push_back(albvp_pkg::CH_VT);
    rx_stream.push_back(albvp_pkg::CH_FF);
    add_line("12");
    add_eol();
    add_line("0x");
    add_line("09");
    add_line("12 ");
    add_line("+");
    add_line("- 5");
    add_line("0x1FF");
    // Text cut short by NUL; what follows it is ignored.
    add_text("7");
    rx_stream.push_back(albvp_pkg::CH_NUL);
    add_line("zz");
    rx_stream.push_back(albvp_pkg::CH_NUL);
    add_eol();
    add_text("0");
    rx_stream.push_back(albvp_pkg::CH_NUL);
    add_eol();
    // Longest line kept, then one character too many.
    add_line("999999999999999");
    add_text("abcdefghijklmnop");
    add_eol();
    rx_stream.push_back(8'hFF);
    add_eol();
    directed_len = rx_stream.size();

    // Random lines: mostly numbers, some damaged, plus noise and long lines.
    near_miss = " \t+-89xXgG.:/";
    while (rx_stream.size() < directed_len + 1950) begin
      kind  = $urandom_range(99);
      first = rx_stream.size();
      if (kind < 80) begin
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(1, 3)) rx_stream.push_back(blank_set[$urandom_range(3)]);
        case ($urandom_range(5))
          1: rx_stream.push_back(albvp_pkg::CH_PLUS);
          2: rx_stream.push_back(albvp_pkg::CH_MINUS);
          default: ;
        endcase
        v = ($urandom_range(7) == 0) ? $urandom_range(4095) : $urandom_range(300);
        case ($urandom_range(2))
          0: digits = $sformatf("%0d", v);
          1: digits = {"0", $sformatf("%0o", v)};
          default: begin
            digits = $sformatf("%0x", v);
            if ($urandom_range(1)) digits = digits.toupper();
            digits = {($urandom_range(1) ? "0x" : "0X"), digits};
          end
        endcase
        add_text(digits);
        if ($urandom_range(9) == 0) begin
          rx_stream.push_back(albvp_pkg::CH_NUL);
          repeat ($urandom_range(3)) rx_stream.push_back(8'($urandom_range(32, 126)));
        end
        // Damage one place of the number text.
        if (kind >= 60) begin
          c   = $urandom_range(1) ? 8'(near_miss[$urandom_range(near_miss.len() - 1)])
                                  : 8'($urandom_range(255));
          pos = $urandom_range(first, rx_stream.size());
          if (pos == rx_stream.size()) rx_stream.push_back(c);
          else rx_stream[pos] = c;
        end
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 18)) rx_stream.push_back(8'($urandom_range(255)));
      end else if (kind < 94) begin
        repeat ($urandom_range(15, 20)) rx_stream.push_back(8'($urandom_range(48, 57)));
      end
      add_eol();
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Three idling phases over the stream.
    n = rx_stream.size();
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) begin
        tx_idle_pct = 59;
        rx_idle_pct = 7;
      end else if (i == (2 * n) / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_beat(rx_stream[i]);
    end
    in_tvalid <= 1'b0;

    // Drain the results still owed, then let the pipeline settle.
    waited = 0;
    while (sb.owed.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (sb.owed.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.owed.size()));

    if (sb.error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/albvp_pkg.sv
rtl/ascii_line_byte_value_parser.sv
verif/tb_ascii_line_byte_value_parser.sv
